/* sv/bdg_pkg.sv */
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared codes, constants and the box-drawing arm table for the
// glyph pixel core.
// ----------------------------------------------------------------------------
package bdg_pkg;

   localparam int unsigned DataWidth = 8;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 3;

   // register indexes
   localparam logic REG_CELL_WIDTH  = 1'b0;
   localparam logic REG_CELL_HEIGHT = 1'b1;

   localparam logic [7:0] CELL_WIDTH_RESET  = 8'd12;
   localparam logic [7:0] CELL_HEIGHT_RESET = 8'd24;

   // character codes
   localparam logic [7:0] CODE_SHADE_LIGHT  = 8'hB0;
   localparam logic [7:0] CODE_SHADE_MEDIUM = 8'hB1;
   localparam logic [7:0] CODE_SHADE_DARK   = 8'hB2;
   localparam logic [7:0] CODE_BOX_FIRST    = 8'hB3;
   localparam logic [7:0] CODE_BOX_LAST     = 8'hDA;
   localparam logic [7:0] CODE_FULL_BLOCK   = 8'hDB;
   localparam logic [7:0] CODE_LOWER_HALF   = 8'hDC;
   localparam logic [7:0] CODE_LEFT_HALF    = 8'hDD;
   localparam logic [7:0] CODE_RIGHT_HALF   = 8'hDE;
   localparam logic [7:0] CODE_UPPER_HALF   = 8'hDF;

   // coverage levels
   localparam logic [7:0] COV_EMPTY  = 8'd0;
   localparam logic [7:0] COV_LIGHT  = 8'd64;
   localparam logic [7:0] COV_MEDIUM = 8'd128;
   localparam logic [7:0] COV_DARK   = 8'd192;
   localparam logic [7:0] COV_FULL   = 8'd255;

   // arm codes
   localparam logic [1:0] ARM_NONE   = 2'd0;
   localparam logic [1:0] ARM_DOUBLE = 2'd2;

   localparam logic [1:0] MIN_STROKE = 2'd2;
   // reciprocal of 3 for values below 128: x/3 == (x*43) >> 7
   localparam logic [6:0] RECIP3_MUL = 7'd43;

   // arms packed as up[7:6] down[5:4] left[3:2] right[1:0]
   function automatic logic [7:0] arm_lookup(input logic [5:0] idx);
      logic [7:0] a;
      case (idx)
         6'd0:  a = 8'h50;  6'd1:  a = 8'h54;  6'd2:  a = 8'h58;  6'd3:  a = 8'hA4;
         6'd4:  a = 8'h24;  6'd5:  a = 8'h18;  6'd6:  a = 8'hA8;  6'd7:  a = 8'hA0;
         6'd8:  a = 8'h28;  6'd9:  a = 8'h88;  6'd10: a = 8'h84;  6'd11: a = 8'h48;
         6'd12: a = 8'h14;  6'd13: a = 8'h41;  6'd14: a = 8'h45;  6'd15: a = 8'h15;
         6'd16: a = 8'h51;  6'd17: a = 8'h05;  6'd18: a = 8'h55;  6'd19: a = 8'h52;
         6'd20: a = 8'hA1;  6'd21: a = 8'h82;  6'd22: a = 8'h22;  6'd23: a = 8'h8A;
         6'd24: a = 8'h2A;  6'd25: a = 8'hA2;  6'd26: a = 8'h0A;  6'd27: a = 8'hAA;
         6'd28: a = 8'h4A;  6'd29: a = 8'h85;  6'd30: a = 8'h1A;  6'd31: a = 8'h25;
         6'd32: a = 8'h81;  6'd33: a = 8'h42;  6'd34: a = 8'h12;  6'd35: a = 8'h21;
         6'd36: a = 8'hA5;  6'd37: a = 8'h5A;  6'd38: a = 8'h44;  6'd39: a = 8'h11;
         default: a = 8'h00;
      endcase
      return a;
   endfunction

endpackage

/* sv/box_drawing_glyph_pixel_core.sv */
// ----------------------------------------------------------------------------
// box_drawing_glyph_pixel_core
// Per-pixel coverage for the procedurally drawn shade, block and
// box-drawing characters, with a configurable cell size.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  char_code, pixel_x, pixel_y
//   rsp_      out        rsp_valid/rsp_ready  coverage, drawn_here
//   csr       in         psel/penable/pready  cell_width, cell_height
//
// One pixel per clock while the response is not stalled; a request passes
// through three registered stages (cell geometry stage, stroke bound stage, compare and output stage).
// Reset clears the valid bits and loads 12 x 24 into the cell registers.
// A stalled response freezes every stage; req_ready drops with it.
//
module box_drawing_glyph_pixel_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_char_code,
   input  logic [7:0]                       req_pixel_x,
   input  logic [7:0]                       req_pixel_y,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_coverage,
   output logic                             rsp_drawn_here,

   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bdg_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [bdg_pkg::CsrDataWidth-1:0] pwdata,
   output logic [bdg_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready
);

   // ---------------- configuration ----------------
   logic [7:0] cell_width_ff, cell_height_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff  <= bdg_pkg::CELL_WIDTH_RESET;
         cell_height_ff <= bdg_pkg::CELL_HEIGHT_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == bdg_pkg::REG_CELL_WIDTH) begin
            cell_width_ff <= pwdata[7:0];
         end else begin
            cell_height_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == bdg_pkg::REG_CELL_WIDTH) begin
         prdata[7:0] = cell_width_ff;
      end else begin
         prdata[7:0] = cell_height_ff;
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage A: cell geometry ----------------
   logic [7:0]  w_in, h_in;
   logic [12:0] tv_prod;
   logic [11:0] th_prod;
   logic [5:0]  tv_q, tv_in;
   logic [4:0]  th_q, th_in;

   always_comb begin
      w_in    = (cell_width_ff == 8'd0) ? 8'd1 : cell_width_ff;
      h_in    = (cell_height_ff == 8'd0) ? 8'd1 : cell_height_ff;
      // w/6 = (w/2)/3, h/12 = (h/4)/3
      tv_prod = {6'd0, w_in[7:1]} * {6'd0, bdg_pkg::RECIP3_MUL};
      th_prod = {6'd0, h_in[7:2]} * {5'd0, bdg_pkg::RECIP3_MUL};
      tv_q    = tv_prod[12:7];
      th_q    = th_prod[11:7];
      tv_in   = (tv_q < {4'd0, bdg_pkg::MIN_STROKE}) ? {4'd0, bdg_pkg::MIN_STROKE} : tv_q;
      th_in   = (th_q < {3'd0, bdg_pkg::MIN_STROKE}) ? {3'd0, bdg_pkg::MIN_STROKE} : th_q;
   end

   logic       a_valid_ff;
   logic [7:0] a_code_ff, a_px_ff, a_py_ff, a_w_ff, a_h_ff;
   logic [5:0] a_tv_ff;
   logic [4:0] a_th_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_code_ff <= req_char_code;
         a_px_ff   <= req_pixel_x;
         a_py_ff   <= req_pixel_y;
         a_w_ff    <= w_in;
         a_h_ff    <= h_in;
         a_tv_ff   <= tv_in;
         a_th_ff   <= th_in;
      end
   end

   // ---------------- stage B: stroke bounds ----------------
   typedef struct packed {
      logic              on;
      logic              dbl;
      logic signed [9:0] span_lo;   // extent along the arm axis
      logic signed [9:0] span_hi;
      logic signed [9:0] lo0;       // first stroke start across the axis
      logic signed [9:0] lo1;       // second stroke start when double
   } stroke_type;

   logic              box_in;
   logic [7:0]        box_off;
   logic [7:0]        arms;
   logic [1:0]        up, dn, lf, rt;
   logic signed [9:0] cx, cy, tv_s, th_s, w_s, h_s;
   stroke_type        vs_in, hs_in;

   always_comb begin
      box_in  = (a_code_ff >= bdg_pkg::CODE_BOX_FIRST) && (a_code_ff <= bdg_pkg::CODE_BOX_LAST);
      box_off = a_code_ff - bdg_pkg::CODE_BOX_FIRST;
      arms    = box_in ? bdg_pkg::arm_lookup(box_off[5:0]) : 8'h00;
      up = arms[7:6];
      dn = arms[5:4];
      lf = arms[3:2];
      rt = arms[1:0];
      cx   = $signed({3'd0, a_w_ff[7:1]});
      cy   = $signed({3'd0, a_h_ff[7:1]});
      tv_s = $signed({4'd0, a_tv_ff});
      th_s = $signed({5'd0, a_th_ff});
      w_s  = $signed({2'd0, a_w_ff});
      h_s  = $signed({2'd0, a_h_ff});

      vs_in.on      = (up != bdg_pkg::ARM_NONE) || (dn != bdg_pkg::ARM_NONE);
      vs_in.dbl     = (up == bdg_pkg::ARM_DOUBLE) || (dn == bdg_pkg::ARM_DOUBLE);
      vs_in.span_lo = (up != bdg_pkg::ARM_NONE) ? 10'sd0 : cy - th_s;
      vs_in.span_hi = (dn != bdg_pkg::ARM_NONE) ? h_s : cy + th_s;
      vs_in.lo0     = cx - (vs_in.dbl ? tv_s : 10'sd0) - (tv_s >>> 1);
      vs_in.lo1     = cx + tv_s - (tv_s >>> 1);

      hs_in.on      = (lf != bdg_pkg::ARM_NONE) || (rt != bdg_pkg::ARM_NONE);
      hs_in.dbl     = (lf == bdg_pkg::ARM_DOUBLE) || (rt == bdg_pkg::ARM_DOUBLE);
      hs_in.span_lo = (lf != bdg_pkg::ARM_NONE) ? 10'sd0 : cx - tv_s;
      hs_in.span_hi = (rt != bdg_pkg::ARM_NONE) ? w_s : cx + tv_s;
      hs_in.lo0     = cy - (hs_in.dbl ? th_s : 10'sd0) - (th_s >>> 1);
      hs_in.lo1     = cy + th_s - (th_s >>> 1);
   end

   logic       b_valid_ff;
   logic [7:0] b_code_ff, b_px_ff, b_py_ff, b_w_ff, b_h_ff;
   logic [5:0] b_tv_ff;
   logic [4:0] b_th_ff;
   logic       b_box_ff;
   stroke_type b_vs_ff, b_hs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_code_ff <= a_code_ff;
         b_px_ff   <= a_px_ff;
         b_py_ff   <= a_py_ff;
         b_w_ff    <= a_w_ff;
         b_h_ff    <= a_h_ff;
         b_tv_ff   <= a_tv_ff;
         b_th_ff   <= a_th_ff;
         b_box_ff  <= box_in;
         b_vs_ff   <= vs_in;
         b_hs_ff   <= hs_in;
      end
   end

   // ---------------- stage C: compare and shade ----------------
   logic signed [9:0] px_s, py_s, btv_s, bth_s;
   logic signed [9:0] dv0, dv1, dh0, dh1;
   logic              v_hit, h_hit, in_cell, hit;
   logic [7:0]        cov_in;
   logic              drawn_in;

   always_comb begin
      px_s  = $signed({2'd0, b_px_ff});
      py_s  = $signed({2'd0, b_py_ff});
      btv_s = $signed({4'd0, b_tv_ff});
      bth_s = $signed({5'd0, b_th_ff});
      dv0   = px_s - b_vs_ff.lo0;
      dv1   = px_s - b_vs_ff.lo1;
      dh0   = py_s - b_hs_ff.lo0;
      dh1   = py_s - b_hs_ff.lo1;

      v_hit = b_vs_ff.on && (py_s >= b_vs_ff.span_lo) && (py_s < b_vs_ff.span_hi) &&
              (((dv0 >= 10'sd0) && (dv0 < btv_s)) ||
               (b_vs_ff.dbl && (dv1 >= 10'sd0) && (dv1 < btv_s)));
      h_hit = b_hs_ff.on && (px_s >= b_hs_ff.span_lo) && (px_s < b_hs_ff.span_hi) &&
              (((dh0 >= 10'sd0) && (dh0 < bth_s)) ||
               (b_hs_ff.dbl && (dh1 >= 10'sd0) && (dh1 < bth_s)));
      hit     = v_hit || h_hit;
      in_cell = (b_px_ff < b_w_ff) && (b_py_ff < b_h_ff);

      drawn_in = 1'b1;
      case (b_code_ff)
         bdg_pkg::CODE_SHADE_LIGHT:  cov_in = bdg_pkg::COV_LIGHT;
         bdg_pkg::CODE_SHADE_MEDIUM: cov_in = bdg_pkg::COV_MEDIUM;
         bdg_pkg::CODE_SHADE_DARK:   cov_in = bdg_pkg::COV_DARK;
         bdg_pkg::CODE_FULL_BLOCK:   cov_in = bdg_pkg::COV_FULL;
         bdg_pkg::CODE_LOWER_HALF:
            cov_in = (b_py_ff >= {1'b0, b_h_ff[7:1]}) ? bdg_pkg::COV_FULL : bdg_pkg::COV_EMPTY;
         bdg_pkg::CODE_LEFT_HALF:
            cov_in = (b_px_ff < {1'b0, b_w_ff[7:1]}) ? bdg_pkg::COV_FULL : bdg_pkg::COV_EMPTY;
         bdg_pkg::CODE_RIGHT_HALF:
            cov_in = (b_px_ff >= {1'b0, b_w_ff[7:1]}) ? bdg_pkg::COV_FULL : bdg_pkg::COV_EMPTY;
         bdg_pkg::CODE_UPPER_HALF:
            cov_in = (b_py_ff < {1'b0, b_h_ff[7:1]}) ? bdg_pkg::COV_FULL : bdg_pkg::COV_EMPTY;
         default: begin
            drawn_in = b_box_ff;
            cov_in   = hit ? bdg_pkg::COV_FULL : bdg_pkg::COV_EMPTY;
         end
      endcase
      // clip to the cell
      if (!in_cell) begin
         cov_in = bdg_pkg::COV_EMPTY;
      end
   end

   logic [7:0] rsp_coverage_ff;
   logic       rsp_drawn_here_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_coverage_ff   <= cov_in;
         rsp_drawn_here_ff <= drawn_in;
      end
   end

   assign rsp_coverage   = rsp_coverage_ff;
   assign rsp_drawn_here = rsp_drawn_here_ff;

endmodule
